// ===== src/frb_pkg.sv =====
package frb_pkg;

   // store depth and frame slots
   localparam int MAX_PAYLOAD = 4096;
   localparam int MAX_FRAMES  = 64;

   // input operation codes
   localparam logic [1:0] OP_FRAME = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_NEW   = 2'd2;

   // result kinds
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   // frame status codes
   localparam logic [1:0] ST_ACCEPTED  = 2'd0;
   localparam logic [1:0] ST_BAD_ID    = 2'd1;
   localparam logic [1:0] ST_DUPLICATE = 2'd2;

   // register indexes
   localparam logic REG_PAYLOAD_BYTES = 1'b0;
   localparam logic REG_FRAME_BYTES   = 1'b1;

   // register reset values and widths
   localparam int          CFG_W         = 13;
   localparam logic [12:0] PAYLOAD_RESET = 13'd4096;
   localparam logic [12:0] FRAME_RESET   = 13'd256;

   // commands from the controller to the datapath
   typedef struct packed {
      logic div_start;
      logic layout_load;
      logic item_take;
   } ctrl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic div_done;
      logic item_result;
   } dp_status_type;

endpackage

// ===== src/frb_ram.sv =====
module frb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/frb_div.sv =====
module frb_div #(
   parameter int N = 12,
   parameter int D = 13
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [N-1:0] dividend,
   input  logic [D-1:0] divisor,
   output logic         done,
   output logic [N-1:0] quotient,
   output logic [D-1:0] remainder
);

   localparam int CW = $clog2(N + 1);

   logic [N-1:0]  quo_ff, quo_in;
   logic [D-1:0]  rem_ff, rem_in;
   logic [D-1:0]  dsr_ff, dsr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [D:0]    trial;
   logic [D:0]    diff;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial   = {rem_ff, quo_ff[N-1]};
      diff    = trial - {1'b0, dsr_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CW'(N);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[D]) begin
            rem_in = diff[D-1:0];
            quo_in = {quo_ff[N-2:0], 1'b1};
         end else begin
            rem_in = trial[D-1:0];
            quo_in = {quo_ff[N-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // operands
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== src/frb_datapath.sv =====
module frb_datapath import frb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   input  logic          cfg_wr,
   input  logic [2:0]    paddr,
   input  logic [31:0]   pwdata,
   output logic [31:0]   prdata,
   input  logic [1:0]    req_op,
   input  logic [7:0]    req_frame_number,
   input  logic [7:0]    req_data_byte,
   input  logic [11:0]   req_read_addr,
   output logic          rsp_kind,
   output logic [1:0]    rsp_status,
   output logic          rsp_complete,
   output logic [6:0]    rsp_frames_left,
   output logic [7:0]    rsp_read_data
);

   localparam int AW  = $clog2(MAX_PAYLOAD);
   localparam int PW  = $clog2(MAX_PAYLOAD + 1);
   localparam int MW  = $clog2(MAX_FRAMES);
   localparam int FCW = $clog2(MAX_FRAMES + 1);
   localparam int XW  = PW + 9;

   function automatic logic [PW-1:0] clamp_len(input logic [CFG_W-1:0] v);
      if (v == '0) begin
         return PW'(1);
      end
      if (32'(v) > MAX_PAYLOAD) begin
         return PW'(MAX_PAYLOAD);
      end
      return PW'(v);
   endfunction

   logic [CFG_W-1:0]    pay_reg_ff, pay_reg_in;
   logic [CFG_W-1:0]    frm_reg_ff, frm_reg_in;
   logic [PW-1:0]       psz, fsz;
   logic [FCW-1:0]      count_ff, count_in;
   logic [PW-1:0]       tail_ff, tail_in;
   logic [FCW-1:0]      missing_ff, missing_in;
   logic [MAX_FRAMES-1:0] map_ff, map_in;
   logic [AW-1:0]       offset_ff, offset_in;
   logic [7:0]          cur_ff, cur_in;
   logic                acc_ff, acc_in;

   logic                kind_ff, kind_in;
   logic [1:0]          stat_ff, stat_in;
   logic                cmpl_ff, cmpl_in;
   logic [6:0]          left_ff, left_in;
   logic                rzero_ff, rzero_in;

   logic                div_done;
   logic [AW-1:0]       div_quo;
   logic [PW-1:0]       div_rem;
   logic [AW:0]         nframes;

   logic                first;
   logic [7:0]          cur;
   logic                acc;
   logic                last_frame;
   logic [PW-1:0]       len;
   logic                final_byte;
   logic [XW-1:0]       addr_full;
   logic                ram_we;
   logic                ram_re;
   logic [AW-1:0]       ram_raddr;
   logic [7:0]          ram_q;
   logic                raddr_ok;

   assign psz = clamp_len(pay_reg_ff);
   assign fsz = clamp_len(frm_reg_ff);

   // frame count and tail length: (p-1) / f gives count-1 and tail-1
   frb_div #(.N(AW), .D(PW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (AW'(psz - PW'(1))),
      .divisor   (fsz),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign nframes = (AW + 1)'(div_quo) + (AW + 1)'(1);

   // per-byte frame decode
   always_comb begin
      first      = (offset_ff == '0);
      cur        = first ? req_frame_number : cur_ff;
      acc        = first ? ((32'(req_frame_number) < 32'(count_ff))
                            && !map_ff[MW'(req_frame_number)])
                         : acc_ff;
      last_frame = (32'(cur) == 32'(count_ff) - 1);
      len        = last_frame ? tail_ff : fsz;
      final_byte = !((PW'(offset_ff) + PW'(1)) < fsz);
      addr_full  = XW'(cur) * XW'(fsz) + XW'(offset_ff);
      ram_we     = cmd.item_take && (req_op == OP_FRAME) && acc
                   && (PW'(offset_ff) < len) && (addr_full < XW'(MAX_PAYLOAD));
      raddr_ok   = (32'(req_read_addr) < MAX_PAYLOAD);
      ram_re     = cmd.item_take && (req_op == OP_READ) && raddr_ok;
      ram_raddr  = AW'(32'(req_read_addr));
   end

   assign status.div_done    = div_done;
   assign status.item_result = ((req_op == OP_FRAME) && final_byte) || (req_op == OP_READ);

   // packet state update
   always_comb begin
      pay_reg_in = pay_reg_ff;
      frm_reg_in = frm_reg_ff;
      count_in   = count_ff;
      tail_in    = tail_ff;
      missing_in = missing_ff;
      map_in     = map_ff;
      offset_in  = offset_ff;
      cur_in     = cur_ff;
      acc_in     = acc_ff;
      kind_in    = kind_ff;
      stat_in    = stat_ff;
      cmpl_in    = cmpl_ff;
      left_in    = left_ff;
      rzero_in   = rzero_ff;
      if (cfg_wr) begin
         if (paddr[2] == REG_PAYLOAD_BYTES) begin
            pay_reg_in = pwdata[CFG_W-1:0];
         end else begin
            frm_reg_in = pwdata[CFG_W-1:0];
         end
         map_in    = '0;
         offset_in = '0;
         cur_in    = '0;
         acc_in    = 1'b0;
      end else if (cmd.layout_load) begin
         if (32'(nframes) > MAX_FRAMES) begin
            count_in = FCW'(MAX_FRAMES);
            tail_in  = fsz;
         end else begin
            count_in = FCW'(nframes);
            tail_in  = div_rem + PW'(1);
         end
         missing_in = count_in;
      end else if (cmd.item_take) begin
         case (req_op)
            OP_FRAME: begin
               if (final_byte) begin
                  if (acc) begin
                     stat_in         = ST_ACCEPTED;
                     map_in[MW'(cur)] = 1'b1;
                     if (missing_ff != '0) begin
                        missing_in = missing_ff - FCW'(1);
                     end
                  end else if (32'(cur) >= 32'(count_ff)) begin
                     stat_in = ST_BAD_ID;
                  end else begin
                     stat_in = ST_DUPLICATE;
                  end
                  kind_in   = KIND_STATUS;
                  cmpl_in   = (missing_in == '0);
                  left_in   = 7'(missing_in);
                  rzero_in  = 1'b1;
                  offset_in = '0;
                  cur_in    = cur;
                  acc_in    = 1'b0;
               end else begin
                  offset_in = offset_ff + AW'(1);
                  cur_in    = cur;
                  acc_in    = acc;
               end
            end
            OP_READ: begin
               kind_in  = KIND_READ;
               stat_in  = ST_ACCEPTED;
               cmpl_in  = 1'b0;
               left_in  = '0;
               rzero_in = !raddr_ok;
            end
            OP_NEW: begin
               map_in     = '0;
               missing_in = count_ff;
               offset_in  = '0;
               cur_in     = '0;
               acc_in     = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pay_reg_ff <= PAYLOAD_RESET;
         frm_reg_ff <= FRAME_RESET;
         count_ff   <= '0;
         tail_ff    <= '0;
         missing_ff <= '0;
         map_ff     <= '0;
         offset_ff  <= '0;
         cur_ff     <= '0;
         acc_ff     <= 1'b0;
      end else begin
         pay_reg_ff <= pay_reg_in;
         frm_reg_ff <= frm_reg_in;
         count_ff   <= count_in;
         tail_ff    <= tail_in;
         missing_ff <= missing_in;
         map_ff     <= map_in;
         offset_ff  <= offset_in;
         cur_ff     <= cur_in;
         acc_ff     <= acc_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      stat_ff  <= stat_in;
      cmpl_ff  <= cmpl_in;
      left_ff  <= left_in;
      rzero_ff <= rzero_in;
   end

   // payload store
   frb_ram #(.WIDTH(8), .DEPTH(MAX_PAYLOAD)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (AW'(addr_full)),
      .wr_data (req_data_byte),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   assign rsp_kind        = kind_ff;
   assign rsp_status      = stat_ff;
   assign rsp_complete    = cmpl_ff;
   assign rsp_frames_left = left_ff;
   assign rsp_read_data   = ((kind_ff == KIND_READ) && !rzero_ff) ? ram_q : 8'd0;

   // register readback
   assign prdata = (paddr[2] == REG_PAYLOAD_BYTES) ? 32'(pay_reg_ff) : 32'(frm_reg_ff);

   // a frame being stored always has an id inside the packet
   a_acc_in_range: assert property (@(posedge clock) disable iff (reset)
      acc_ff |-> (32'(cur_ff) < 32'(count_ff)))
      else $error("stored frame id outside the packet");

   // missing frames never exceed the frame count
   a_missing_le_count: assert property (@(posedge clock) disable iff (reset)
      missing_ff <= count_ff)
      else $error("missing count above frame count");

   // byte position stays inside the frame
   a_offset_in_frame: assert property (@(posedge clock) disable iff (reset)
      32'(offset_ff) < 32'(fsz))
      else $error("byte offset past frame size");

endmodule

// ===== src/frb_ctrl.sv =====
module frb_ctrl import frb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          cfg_wr,
   input  logic          req_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd,
   output logic          req_stall,
   output logic          rsp_valid
);

   typedef enum logic [2:0] {
      S_START  = 3'b001,
      S_DIVIDE = 3'b010,
      S_RUN    = 3'b100
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // sequencing: layout divide after reset or a register write, then run
   always_comb begin
      state_in        = state_ff;
      cmd.div_start   = 1'b0;
      cmd.layout_load = 1'b0;
      cmd.item_take   = req_valid && !req_stall;
      case (state_ff)
         S_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIVIDE;
         end
         S_DIVIDE: begin
            if (status.div_done) begin
               cmd.layout_load = 1'b1;
               state_in        = S_RUN;
            end
         end
         S_RUN: begin
            state_in = S_RUN;
         end
         default: begin
            state_in = S_START;
         end
      endcase
      if (cfg_wr) begin
         state_in = S_START;
      end
   end

   // input beat taken when running and the result slot is free
   assign req_stall = (state_ff != S_RUN) || (rsp_valid_ff && rsp_stall);

   // result slot
   always_comb begin
      if (cmd.item_take && status.item_result) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // no input beat while the layout is being worked out
   a_stall_outside_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_RUN) |-> req_stall)
      else $error("input open before layout is ready");

   // a finished divide brings the block into run
   a_divide_to_run: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DIVIDE) && status.div_done && !cfg_wr) |=> (state_ff == S_RUN))
      else $error("divide done but block not running");

   // a register write restarts the layout
   a_cfg_restart: assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> (state_ff == S_START))
      else $error("register write did not restart layout");

endmodule

// ===== src/frame_reassembly_buffer_top.sv =====
// Frame reassembly buffer: rebuilds one packet from numbered frames streamed one
// byte per beat. One beat is taken per cycle while the result register is free;
// a read result shows its data from the payload RAM's registered port in the
// cycle after the beat is taken. After reset and after every register write, the
// frame count and last-frame length are worked out by a bit-serial divider, and
// input is stalled until the layout is loaded. Register writes also start a new
// packet. Registers: payload_bytes at 0x0, frame_bytes at 0x4, both 13 bits and
// clamped to 1..MAX_PAYLOAD.
module frame_reassembly_buffer_top import frb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_frame_number,
   input  logic [7:0]  req_data_byte,
   input  logic [11:0] req_read_addr,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [1:0]  rsp_status,
   output logic        rsp_complete,
   output logic [6:0]  rsp_frames_left,
   output logic [7:0]  rsp_read_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          cfg_wr;

   // register write completes on the access cycle
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && pready;

   frb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg_wr    (cfg_wr),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid)
   );

   frb_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .cfg_wr           (cfg_wr),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .req_op           (req_op),
      .req_frame_number (req_frame_number),
      .req_data_byte    (req_data_byte),
      .req_read_addr    (req_read_addr),
      .rsp_kind         (rsp_kind),
      .rsp_status       (rsp_status),
      .rsp_complete     (rsp_complete),
      .rsp_frames_left  (rsp_frames_left),
      .rsp_read_data    (rsp_read_data)
   );

endmodule
